// File: design/smds_pkg.sv
package smds_pkg;

  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 3'd0,
    MODE_FAST_ADD = 3'd1,
    MODE_GET      = 3'd2,
    MODE_REMOVE   = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_SCAN,
    S_LOOK,
    S_FETCH,
    S_SHIFT,
    S_WALK,
    S_CLEAR,
    S_RESP
  } state_e;

  // first field in the highest bits
  typedef struct packed {
    logic [DATA_W-1:0] entry_data;
    logic [SLOT_W-1:0] slot;
    logic [MODE_W-1:0] mode;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_out;
    logic [DATA_W-1:0]  data_out;
    logic [SLOT_W-1:0]  slot_out;
    status_e            status;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage

// File: design/slot_map_dense_store.sv
// Slot map with a packed entry store: one result item per input item, one item
// in flight at a time. Both the slot map and the store sit in single-port-write,
// registered-read memories, and every operation is a walk of the sequencer over
// them. An add scans for the lowest free slot, a clear wipes every slot, and a
// remove moves the later entries down and then renumbers the mappings in a pass
// over all slots, which dominates its cost. After reset the slot map is wiped
// in a pass over all CAPACITY entries with s_axis_tready low. A finished result
// sits in an output register, so the next item is taken while it waits.
module slot_map_dense_store #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // mode[2:0], slot[7:3], entry_data[39:8]
  input  logic [smds_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[1:0], slot_out[6:2], data_out[38:7], count_out[44:39], zeros above
  output logic [smds_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned MW = IW + 1;

  smds_pkg::item_t   in_item;
  smds_pkg::result_t res;
  logic              res_valid;
  logic              res_ready;

  logic                  out_valid_q, out_valid_d;
  smds_pkg::result_t     out_res_q, out_res_d;

  logic                  map_we;
  logic [IW-1:0]         map_waddr;
  logic [MW-1:0]         map_wdata;
  logic [IW-1:0]         map_raddr;
  logic [MW-1:0]         map_rdata;
  logic                  st_we;
  logic [IW-1:0]         st_waddr;
  logic [ENTRY_BITS-1:0] st_wdata;
  logic [IW-1:0]         st_raddr;
  logic [ENTRY_BITS-1:0] st_rdata;

  assign in_item = smds_pkg::item_t'(s_axis_tdata);

  smds_seq #(
    .CAPACITY  (CAPACITY),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .map_we_o    (map_we),
    .map_waddr_o (map_waddr),
    .map_wdata_o (map_wdata),
    .map_raddr_o (map_raddr),
    .map_rdata_i (map_rdata),
    .st_we_o     (st_we),
    .st_waddr_o  (st_waddr),
    .st_wdata_o  (st_wdata),
    .st_raddr_o  (st_raddr),
    .st_rdata_i  (st_rdata)
  );

  // valid bit and store position per slot
  smds_ram #(
    .WIDTH(MW),
    .DEPTH(CAPACITY)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  smds_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(CAPACITY)
  ) u_store_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = smds_pkg::OUT_W'(out_res_q);

endmodule

// File: design/smds_ram.sv
module smds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/smds_seq.sv
module smds_seq #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned ENTRY_BITS = 32,
  localparam int unsigned IW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned MW = IW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  smds_pkg::item_t       in_item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output smds_pkg::result_t     res_o,
  output logic                  map_we_o,
  output logic [IW-1:0]         map_waddr_o,
  output logic [MW-1:0]         map_wdata_o,
  output logic [IW-1:0]         map_raddr_o,
  input  logic [MW-1:0]         map_rdata_i,
  output logic                  st_we_o,
  output logic [IW-1:0]         st_waddr_o,
  output logic [ENTRY_BITS-1:0] st_wdata_o,
  output logic [IW-1:0]         st_raddr_o,
  input  logic [ENTRY_BITS-1:0] st_rdata_i
);

  smds_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     pos_q, pos_d;
  smds_pkg::mode_e   mode_q, mode_d;
  logic [smds_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [ENTRY_BITS-1:0]       data_q, data_d;
  smds_pkg::status_e           status_q, status_d;
  logic [smds_pkg::SLOT_W-1:0] slot_out_q, slot_out_d;
  logic [smds_pkg::DATA_W-1:0] data_out_q, data_out_d;

  logic          map_valid;
  logic [IW-1:0] map_pos;
  logic          idx_last;
  logic          count_full;
  logic          slot_ok;
  logic [IW-1:0] slot_idx;

  assign map_valid  = map_rdata_i[IW];
  assign map_pos    = map_rdata_i[IW-1:0];
  assign idx_last   = (idx_q == CW'(CAPACITY - 1));
  assign count_full = (32'(count_q) >= 32'(CAPACITY));
  assign slot_ok    = (32'(slot_q) < 32'(CAPACITY));
  assign slot_idx   = IW'(slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smds_pkg::S_INIT;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    mode_q     <= mode_d;
    slot_q     <= slot_d;
    data_q     <= data_d;
    status_q   <= status_d;
    slot_out_q <= slot_out_d;
    data_out_q <= data_out_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    mode_d     = mode_q;
    slot_d     = slot_q;
    data_d     = data_q;
    status_d   = status_q;
    slot_out_d = slot_out_q;
    data_out_d = data_out_q;

    in_ready_o  = (state_q == smds_pkg::S_IDLE);
    res_valid_o = (state_q == smds_pkg::S_RESP);

    map_we_o    = 1'b0;
    map_waddr_o = idx_q[IW-1:0];
    map_wdata_o = '0;
    map_raddr_o = '0;
    st_we_o     = 1'b0;
    st_waddr_o  = idx_q[IW-1:0];
    st_wdata_o  = st_rdata_i;
    st_raddr_o  = '0;

    case (state_q)
      smds_pkg::S_INIT: begin
        // clearing pass over the slot map after reset
        map_we_o = 1'b1;
        if (idx_last) begin
          idx_d   = '0;
          state_d = smds_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      smds_pkg::S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = smds_pkg::mode_e'(in_item_i.mode);
          slot_d  = in_item_i.slot;
          data_d  = ENTRY_BITS'(in_item_i.entry_data);
          state_d = smds_pkg::S_START;
        end
      end

      smds_pkg::S_START: begin
        status_d   = smds_pkg::ST_OK;
        slot_out_d = '0;
        data_out_d = '0;
        idx_d      = '0;
        case (mode_q)
          smds_pkg::MODE_ADD: begin
            if (count_full) begin
              status_d = smds_pkg::ST_FULL;
              state_d  = smds_pkg::S_RESP;
            end else begin
              state_d = smds_pkg::S_SCAN;
            end
          end
          smds_pkg::MODE_FAST_ADD: begin
            if (count_full) begin
              status_d = smds_pkg::ST_FULL;
            end else begin
              map_we_o    = 1'b1;
              map_waddr_o = count_q[IW-1:0];
              map_wdata_o = {1'b1, count_q[IW-1:0]};
              st_we_o     = 1'b1;
              st_waddr_o  = count_q[IW-1:0];
              st_wdata_o  = data_q;
              slot_out_d  = smds_pkg::SLOT_W'(count_q);
              count_d     = count_q + CW'(1);
            end
            state_d = smds_pkg::S_RESP;
          end
          smds_pkg::MODE_GET, smds_pkg::MODE_REMOVE: begin
            if (!slot_ok) begin
              status_d = smds_pkg::ST_EMPTY;
              state_d  = smds_pkg::S_RESP;
            end else begin
              map_raddr_o = slot_idx;
              state_d     = smds_pkg::S_LOOK;
            end
          end
          smds_pkg::MODE_CLEAR: begin
            count_d = '0;
            state_d = smds_pkg::S_CLEAR;
          end
          default: begin
            state_d = smds_pkg::S_RESP;
          end
        endcase
      end

      smds_pkg::S_SCAN: begin
        // map data for idx_q arrives now, next index already requested
        map_raddr_o = IW'(idx_q + CW'(1));
        if (!map_valid) begin
          map_we_o    = 1'b1;
          map_wdata_o = {1'b1, count_q[IW-1:0]};
          st_we_o     = 1'b1;
          st_waddr_o  = count_q[IW-1:0];
          st_wdata_o  = data_q;
          slot_out_d  = smds_pkg::SLOT_W'(idx_q);
          count_d     = count_q + CW'(1);
          state_d     = smds_pkg::S_RESP;
        end else if (idx_last) begin
          status_d = smds_pkg::ST_FULL;
          state_d  = smds_pkg::S_RESP;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      smds_pkg::S_LOOK: begin
        if (!map_valid) begin
          status_d = smds_pkg::ST_EMPTY;
          state_d  = smds_pkg::S_RESP;
        end else if (mode_q == smds_pkg::MODE_GET) begin
          st_raddr_o = map_pos;
          state_d    = smds_pkg::S_FETCH;
        end else if (CW'(map_pos) >= count_q) begin
          status_d = smds_pkg::ST_EMPTY;
          state_d  = smds_pkg::S_RESP;
        end else begin
          pos_d      = map_pos;
          st_raddr_o = IW'(CW'(map_pos) + CW'(1));
          if ((CW'(map_pos) + CW'(1)) < count_q) begin
            idx_d   = CW'(map_pos);
            state_d = smds_pkg::S_SHIFT;
          end else begin
            // removed entry is the last one, nothing to move
            count_d = count_q - CW'(1);
            idx_d   = '0;
            state_d = smds_pkg::S_WALK;
          end
        end
      end

      smds_pkg::S_FETCH: begin
        data_out_d = smds_pkg::DATA_W'(st_rdata_i);
        state_d    = smds_pkg::S_RESP;
      end

      smds_pkg::S_SHIFT: begin
        // entry idx_q+1 arrives and moves down to idx_q
        st_we_o    = 1'b1;
        st_wdata_o = st_rdata_i;
        st_raddr_o = IW'(idx_q + CW'(2));
        if (({1'b0, idx_q} + (CW + 1)'(2)) < {1'b0, count_q}) begin
          idx_d = idx_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
          idx_d   = '0;
          state_d = smds_pkg::S_WALK;
        end
      end

      smds_pkg::S_WALK: begin
        // renumber mappings above the gap and free the removed slot
        map_raddr_o = IW'(idx_q + CW'(1));
        map_we_o    = 1'b1;
        if (idx_q[IW-1:0] == slot_idx) begin
          map_wdata_o = '0;
        end else if (map_valid && (map_pos > pos_q)) begin
          map_wdata_o = {1'b1, map_pos - IW'(1)};
        end else begin
          map_wdata_o = map_rdata_i;
        end
        if (idx_last) begin
          idx_d   = '0;
          state_d = smds_pkg::S_RESP;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      smds_pkg::S_CLEAR: begin
        map_we_o = 1'b1;
        if (idx_last) begin
          idx_d   = '0;
          state_d = smds_pkg::S_RESP;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      smds_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = smds_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = smds_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.count_out = smds_pkg::COUNT_W'(count_q);
    res_o.data_out  = data_out_q;
    res_o.slot_out  = slot_out_q;
    res_o.status    = status_q;
  end

endmodule

// File: design/smds_chk.sv
module smds_chk #(
  parameter int unsigned CAPACITY = 32
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [smds_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [smds_pkg::OUT_W-1:0] m_axis_tdata
);

  smds_pkg::result_t res;

  assign res = smds_pkg::result_t'(m_axis_tdata[smds_pkg::RES_W-1:0]);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: the sequencer is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again right after an accept");

  // a full answer only comes with a full table
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.status == smds_pkg::ST_FULL) |->
      (res.count_out == 6'(CAPACITY)) && (res.slot_out == '0) && (res.data_out == '0))
    else $error("full status with table not full");

  // no reserved status code, and slot and data never both set
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((res.status == smds_pkg::ST_OK) || (res.status == smds_pkg::ST_FULL) ||
       (res.status == smds_pkg::ST_EMPTY)) &&
      ((res.slot_out == '0) || (res.data_out == '0)))
    else $error("malformed result item");

endmodule

bind slot_map_dense_store smds_chk #(.CAPACITY(CAPACITY)) u_smds_chk (.*);

// File: dv/slot_map_dense_store_tb.sv
module slot_map_dense_store_tb;
  import smds_pkg::*;

  localparam int unsigned TBL_CAP = 32;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 120;
  // mode codes the block leaves alone
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  slot_map_dense_store #(
    .CAPACITY  (TBL_CAP),
    .ENTRY_BITS(DATA_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the slot table
  bit                 tbl_valid[TBL_CAP];
  logic [COUNT_W-1:0] tbl_pos[TBL_CAP];
  logic [DATA_W-1:0]  tbl_store[TBL_CAP];
  logic [COUNT_W-1:0] tbl_count;

  result_t     pending_answers[$];
  int unsigned fail_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic result_t slot_table_step(item_t it);
    result_t     r;
    int unsigned i;
    int unsigned p;
    r.status    = ST_OK;
    r.slot_out  = '0;
    r.data_out  = '0;
    r.count_out = '0;
    case (it.mode)
      MODE_ADD: begin
        i = 0;
        while (i < TBL_CAP && tbl_valid[i]) i++;
        if (tbl_count >= TBL_CAP || i >= TBL_CAP) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[i] = 1'b1;
          tbl_pos[i] = tbl_count;
          tbl_store[tbl_count] = it.entry_data;
          tbl_count++;
          r.slot_out = 5'(i);
        end
      end
      MODE_FAST_ADD: begin
        if (tbl_count >= TBL_CAP) begin
          r.status = ST_FULL;
        end else begin
          // may overwrite a live slot, its old entry becomes unreachable
          i = 32'(tbl_count);
          tbl_valid[i] = 1'b1;
          tbl_pos[i] = tbl_count;
          tbl_store[tbl_count] = it.entry_data;
          tbl_count++;
          r.slot_out = 5'(i);
        end
      end
      MODE_GET: begin
        if (!tbl_valid[it.slot] || tbl_pos[it.slot] >= TBL_CAP) r.status = ST_EMPTY;
        else r.data_out = tbl_store[tbl_pos[it.slot]];
      end
      MODE_REMOVE: begin
        if (!tbl_valid[it.slot] || tbl_pos[it.slot] >= tbl_count) begin
          r.status = ST_EMPTY;
        end else begin
          p = 32'(tbl_pos[it.slot]);
          for (i = p; i + 1 < tbl_count; i++) tbl_store[i] = tbl_store[i+1];
          tbl_count--;
          for (i = 0; i < TBL_CAP; i++)
            if (tbl_valid[i] && tbl_pos[i] > p) tbl_pos[i]--;
          tbl_valid[it.slot] = 1'b0;
          tbl_pos[it.slot] = '0;
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < TBL_CAP; i++) begin
          tbl_valid[i] = 1'b0;
          tbl_pos[i] = '0;
        end
        tbl_count = '0;
      end
      default: ;
    endcase
    r.count_out = tbl_count;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] random_used_slot();
    logic [SLOT_W-1:0] live[$];
    for (int i = 0; i < TBL_CAP; i++)
      if (tbl_valid[i]) live.push_back(SLOT_W'(i));
    if (live.size() == 0) return SLOT_W'($urandom_range(TBL_CAP - 1));
    return live[$urandom_range(live.size() - 1)];
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                           input logic [DATA_W-1:0] data);
    item_t it;
    it.mode = mode;
    it.slot = slot;
    it.entry_data = data;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_answers.push_back(slot_table_step(it));
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  task automatic test_empty_lookups();
    send_item(MODE_GET, 5'd0, 32'h0);
    send_item(MODE_GET, 5'd31, 32'hFFFF_FFFF);
    send_item(MODE_REMOVE, 5'd31, 32'h0);
  endtask

  task automatic test_add_and_get();
    send_item(MODE_ADD, 5'd31, 32'h0000_0000);
    send_item(MODE_ADD, 5'd0, 32'hFFFF_FFFF);
    send_item(MODE_FAST_ADD, 5'd17, 32'hA5A5_5A5A);
    send_item(MODE_GET, 5'd0, 32'h0);
    send_item(MODE_GET, 5'd1, 32'h0);
    send_item(MODE_GET, 5'd2, 32'h0);
  endtask

  task automatic test_fast_add_overwrite();
    send_item(MODE_REMOVE, 5'd0, 32'h0);
    // count is now 2 and slot 2 is live, so the fast add lands on it
    send_item(MODE_FAST_ADD, 5'd0, 32'h1234_5678);
    send_item(MODE_GET, 5'd2, 32'h0);
    send_item(MODE_GET, 5'd1, 32'h0);
    send_item(MODE_REMOVE, 5'd1, 32'h0);
    send_item(MODE_GET, 5'd2, 32'h0);
  endtask

  task automatic test_unused_modes();
    send_item(MODE_UNUSED_LO, 5'd0, 32'h0);
    send_item(MODE_UNUSED_LO + 3'd1, 5'd2, $urandom());
    send_item(MODE_UNUSED_HI, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_clear();
    send_item(MODE_CLEAR, 5'd2, 32'h0);
    send_item(MODE_GET, 5'd2, 32'h0);
    send_item(MODE_ADD, 5'd9, 32'hDEAD_BEEF);
  endtask

  task automatic test_full_table();
    while (tbl_count < TBL_CAP)
      send_item(($urandom_range(3) == 0) ? MODE_FAST_ADD : MODE_ADD,
                SLOT_W'($urandom_range(31)), $urandom());
    send_item(MODE_ADD, SLOT_W'($urandom_range(31)), $urandom());
    send_item(MODE_FAST_ADD, SLOT_W'($urandom_range(31)), $urandom());
    send_item(MODE_GET, random_used_slot(), $urandom());
    send_item(MODE_REMOVE, random_used_slot(), $urandom());
    send_item(MODE_ADD, SLOT_W'($urandom_range(31)), $urandom());
  endtask

  task automatic test_random_ops(input int unsigned n_items);
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    int unsigned       pick;
    repeat (n_items) begin
      slot = SLOT_W'($urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 30) begin
        mode = MODE_ADD;
      end else if (pick < 40) begin
        mode = MODE_FAST_ADD;
      end else if (pick < 65) begin
        mode = MODE_GET;
        if ($urandom_range(3) != 0) slot = random_used_slot();
      end else if (pick < 92) begin
        mode = MODE_REMOVE;
        if ($urandom_range(3) != 0) slot = random_used_slot();
      end else if (pick < 95) begin
        mode = MODE_CLEAR;
      end else begin
        mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      end
      send_item(mode, slot, $urandom());
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

  function automatic void cmp_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RES_W-1:0]);
      if (pending_answers.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item, expected none actual %0h", $time, m_axis_tdata);
      end else begin
        want = pending_answers.pop_front();
        cmp_field("status", 64'(want.status), 64'(got.status));
        cmp_field("slot_out", 64'(want.slot_out), 64'(got.slot_out));
        cmp_field("data_out", 64'(want.data_out), 64'(got.data_out));
        cmp_field("count_out", 64'(want.count_out), 64'(got.count_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("slot_map_dense_store test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TBL_CAP; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_pos[i] = '0;
      tbl_store[i] = '0;
    end
    tbl_count = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idling(0, 0);
    test_empty_lookups();
    test_add_and_get();
    test_fast_add_overwrite();
    test_unused_modes();
    test_clear();

    set_idling(0, 0);
    test_random_ops(200);
    test_full_table();
    set_idling(81, 0);
    test_random_ops(200);
    test_full_table();
    set_idling(0, 81);
    test_full_table();
    test_random_ops(200);
    set_idling(35, 35);
    test_random_ops(200);
    test_full_table();

    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("slot_map_dense_store test passed");
    end else begin
      $display("slot_map_dense_store test failed");
    end
    $finish;
  end

endmodule
